// ----- hdl/shacal2_pkg.sv -----
// ----------------------------------------------------------------------------
// SHACAL-2 package
// Word and block types and operation codes shared by the cipher top level and
// its round stage, and the round functions that the stage applies.
// ----------------------------------------------------------------------------
`default_nettype none

package shacal2_pkg;

  localparam int unsigned RoundsDefault = 64;
  localparam int unsigned RoundsMax     = 64;
  localparam int unsigned WordW         = 32;
  localparam int unsigned OpW           = 2;
  localparam int unsigned KeyIndexW     = 6;

  typedef logic [WordW-1:0] word_t;
  // index 0 is word A, index 7 is word H
  typedef word_t [7:0] block_t;

  typedef enum logic [OpW-1:0] {
    OP_LOAD    = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2,
    OP_IGNORE  = 2'd3
  } op_e;

  typedef struct packed {
    logic valid;
    logic dec;
  } stage_ctrl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ch32(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj32(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic block_t round_fwd(input block_t w, input word_t k);
    word_t  t1;
    word_t  t2;
    block_t r;
    t1   = w[7] + big_sigma1(w[4]) + ch32(w[4], w[5], w[6]) + k;
    t2   = big_sigma0(w[0]) + maj32(w[0], w[1], w[2]);
    r[7] = w[6];
    r[6] = w[5];
    r[5] = w[4];
    r[4] = w[3] + t1;
    r[3] = w[2];
    r[2] = w[1];
    r[1] = w[0];
    r[0] = t1 + t2;
    return r;
  endfunction

  function automatic block_t round_inv(input block_t w, input word_t k);
    word_t  t1;
    word_t  t2;
    block_t r;
    t2   = big_sigma0(w[1]) + maj32(w[1], w[2], w[3]);
    t1   = w[0] - t2;
    r[0] = w[1];
    r[1] = w[2];
    r[2] = w[3];
    r[3] = w[4] - t1;
    r[4] = w[5];
    r[5] = w[6];
    r[6] = w[7];
    r[7] = t1 - big_sigma1(w[5]) - ch32(w[5], w[6], w[7]) - k;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/shacal2_stage.sv -----
// ----------------------------------------------------------------------------
// SHACAL-2 round stage
// One registered cipher round, forward or inverse as the beat's direction
// flag selects. Holds while the pipeline stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module shacal2_stage import shacal2_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire stage_ctrl_t ctrl_i,
  input  wire block_t      blk_i,
  input  wire word_t       key_i,
  output stage_ctrl_t      ctrl_o,
  output block_t           blk_o
);

  stage_ctrl_t ctrl_q;
  block_t      blk_q;
  block_t      blk_d;

  always_comb begin
    blk_d = ctrl_i.dec ? round_inv(blk_i, key_i) : round_fwd(blk_i, key_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctrl_i.valid) begin
      blk_q <= blk_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign blk_o  = blk_q;

endmodule

`default_nettype wire

// ----- hdl/shacal2_block_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// SHACAL-2 block cipher unit
// 256-bit block cipher, one round per pipeline stage, loaded round keys.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------
//  in      | sink      | in_valid_i / in_ready_o  | operation, key_index,
//          |           |                          | key_word, in_word_a..h
//  out     | source    | out_valid_o / out_ready_i| out_word_a..h
//
//  Encrypt/decrypt beats enter every cycle while the output is not stalled;
//  a result leaves from the last round register, which serves as output.
//  A key load is accepted only once all stages and the output are empty, so
//  blocks in flight keep the keys they entered with.
//  Reset clears the stage valid bits and every round key to zero.
//  A stalled output freezes all stages; no beat is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module shacal2_block_cipher_unit import shacal2_pkg::*; #(
  parameter int unsigned Rounds = RoundsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [OpW-1:0]       operation_i,
  input  wire logic [KeyIndexW-1:0] key_index_i,
  input  wire logic [WordW-1:0]     key_word_i,
  input  wire logic [WordW-1:0]     in_word_a_i,
  input  wire logic [WordW-1:0]     in_word_b_i,
  input  wire logic [WordW-1:0]     in_word_c_i,
  input  wire logic [WordW-1:0]     in_word_d_i,
  input  wire logic [WordW-1:0]     in_word_e_i,
  input  wire logic [WordW-1:0]     in_word_f_i,
  input  wire logic [WordW-1:0]     in_word_g_i,
  input  wire logic [WordW-1:0]     in_word_h_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [WordW-1:0]          out_word_a_o,
  output logic [WordW-1:0]          out_word_b_o,
  output logic [WordW-1:0]          out_word_c_o,
  output logic [WordW-1:0]          out_word_d_o,
  output logic [WordW-1:0]          out_word_e_o,
  output logic [WordW-1:0]          out_word_f_o,
  output logic [WordW-1:0]          out_word_g_o,
  output logic [WordW-1:0]          out_word_h_o
);

  localparam int unsigned SelW = KeyIndexW + 1;

  op_e         op;
  logic        is_load;
  logic        is_cipher;
  logic        advance;
  logic        pipe_empty;
  logic        load_we;
  logic        in_fire;
  logic [Rounds-1:0] valid_vec;

  word_t       key_q [Rounds];
  stage_ctrl_t ctrl_s [Rounds+1];
  block_t      blk_s [Rounds+1];

  assign op        = op_e'(operation_i);
  assign is_load   = (op == OP_LOAD);
  assign is_cipher = (op == OP_ENCRYPT) || (op == OP_DECRYPT);

  assign advance    = !ctrl_s[Rounds].valid || out_ready_i;
  assign pipe_empty = ~|valid_vec;
  assign in_ready_o = is_load ? pipe_empty : advance;
  assign in_fire    = in_valid_i && in_ready_o;
  // key entries past the last round are never read
  assign load_we    = in_fire && is_load && ({1'b0, key_index_i} < SelW'(Rounds));

  // round key store, one register per round
  for (genvar r = 0; r < Rounds; r++) begin : g_key
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        key_q[r] <= '0;
      end else if (load_we && (key_index_i == KeyIndexW'(r))) begin
        key_q[r] <= key_word_i;
      end
    end
  end

  assign ctrl_s[0].valid = in_fire && is_cipher;
  assign ctrl_s[0].dec   = (op == OP_DECRYPT);
  assign blk_s[0] = {in_word_h_i, in_word_g_i, in_word_f_i, in_word_e_i,
                     in_word_d_i, in_word_c_i, in_word_b_i, in_word_a_i};

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    word_t key;
    assign key = ctrl_s[r].dec ? key_q[Rounds-1-r] : key_q[r];

    shacal2_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .ctrl_i (ctrl_s[r]),
      .blk_i  (blk_s[r]),
      .key_i  (key),
      .ctrl_o (ctrl_s[r+1]),
      .blk_o  (blk_s[r+1])
    );

    assign valid_vec[r] = ctrl_s[r+1].valid;
  end

  assign out_valid_o  = ctrl_s[Rounds].valid;
  assign out_word_a_o = blk_s[Rounds][0];
  assign out_word_b_o = blk_s[Rounds][1];
  assign out_word_c_o = blk_s[Rounds][2];
  assign out_word_d_o = blk_s[Rounds][3];
  assign out_word_e_o = blk_s[Rounds][4];
  assign out_word_f_o = blk_s[Rounds][5];
  assign out_word_g_o = blk_s[Rounds][6];
  assign out_word_h_o = blk_s[Rounds][7];

  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_load) |-> (valid_vec == '0))
    else $error("key load accepted with blocks in flight");

  a_cipher_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_cipher) |=> ctrl_s[1].valid)
    else $error("accepted block missing from first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(valid_vec))
    else $error("stage valid bits moved during stall");

  a_beat_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ctrl_s[1].valid) |=> ctrl_s[2].valid)
    else $error("block lost between stages");

  a_load_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_cipher) |=> !ctrl_s[1].valid)
    else $error("non-cipher beat entered pipeline");

endmodule

`default_nettype wire

// ----- test/shacal2_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHACAL-2 result checker
// Watches both channels of the cipher unit. It keeps its own round key store,
// enciphers or deciphers every accepted block beat, and compares each result
// beat word by word with the oldest expected block.
// ----------------------------------------------------------------------------
module shacal2_result_checker import shacal2_pkg::*; #(
  parameter int unsigned Rounds = RoundsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [OpW-1:0]       operation_i,
  input  logic [KeyIndexW-1:0] key_index_i,
  input  logic [WordW-1:0]     key_word_i,
  input  logic [WordW-1:0]     in_word_a_i,
  input  logic [WordW-1:0]     in_word_b_i,
  input  logic [WordW-1:0]     in_word_c_i,
  input  logic [WordW-1:0]     in_word_d_i,
  input  logic [WordW-1:0]     in_word_e_i,
  input  logic [WordW-1:0]     in_word_f_i,
  input  logic [WordW-1:0]     in_word_g_i,
  input  logic [WordW-1:0]     in_word_h_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [WordW-1:0]     out_word_a_i,
  input  logic [WordW-1:0]     out_word_b_i,
  input  logic [WordW-1:0]     out_word_c_i,
  input  logic [WordW-1:0]     out_word_d_i,
  input  logic [WordW-1:0]     out_word_e_i,
  input  logic [WordW-1:0]     out_word_f_i,
  input  logic [WordW-1:0]     out_word_g_i,
  input  logic [WordW-1:0]     out_word_h_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   checked_o
);

  localparam int unsigned KeyDepth = 1 << KeyIndexW;

  word_t  round_keys [KeyDepth];
  block_t expected_blocks [$];

  function automatic word_t ror(input word_t x, input int unsigned n);
    logic [2*WordW-1:0] twice;
    twice = {x, x} >> n;
    return twice[WordW-1:0];
  endfunction

  function automatic word_t rot_mix_a(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t rot_mix_e(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return g ^ (e & (f ^ g));
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) | (c & (a | b));
  endfunction

  // word A sits at index 0, word H at index 7
  function automatic block_t encipher(input block_t b);
    word_t t1;
    word_t t2;
    for (int r = 0; r < Rounds; r++) begin
      t1 = b[7] + rot_mix_e(b[4]) + choose(b[4], b[5], b[6]) + round_keys[r % KeyDepth];
      t2 = rot_mix_a(b[0]) + majority(b[0], b[1], b[2]);
      b = {b[6:0], t1 + t2};
      b[4] = b[4] + t1;
    end
    return b;
  endfunction

  function automatic block_t decipher(input block_t b);
    word_t t1;
    word_t t2;
    word_t d_prev;
    word_t h_prev;
    for (int r = Rounds - 1; r >= 0; r--) begin
      t2 = rot_mix_a(b[1]) + majority(b[1], b[2], b[3]);
      t1 = b[0] - t2;
      d_prev = b[4] - t1;
      h_prev = t1 - rot_mix_e(b[5]) - choose(b[5], b[6], b[7]) - round_keys[r % KeyDepth];
      b = {h_prev, b[7:1]};
      b[3] = d_prev;
    end
    return b;
  endfunction

  always @(posedge clk_i) begin : monitor
    block_t in_block;
    block_t seen;
    block_t want;
    if (!rst_ni) begin
      foreach (round_keys[i]) round_keys[i] = '0;
      expected_blocks.delete();
      mismatches_o = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = {out_word_h_i, out_word_g_i, out_word_f_i, out_word_e_i,
                out_word_d_i, out_word_c_i, out_word_b_i, out_word_a_i};
        if (expected_blocks.size() == 0) begin
          $error("result beat with no block pending: %h", seen);
          mismatches_o++;
        end else begin
          want = expected_blocks.pop_front();
          checked_o++;
          for (int i = 0; i < 8; i++) begin
            if (seen[i] !== want[i]) begin
              $error("out_word_%c: expected %h, got %h", 8'(97 + i), want[i], seen[i]);
              mismatches_o++;
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        in_block = {in_word_h_i, in_word_g_i, in_word_f_i, in_word_e_i,
                    in_word_d_i, in_word_c_i, in_word_b_i, in_word_a_i};
        case (operation_i)
          OP_LOAD:    round_keys[key_index_i] = key_word_i;
          OP_ENCRYPT: expected_blocks.push_back(encipher(in_block));
          OP_DECRYPT: expected_blocks.push_back(decipher(in_block));
          default:    ;
        endcase
      end
    end
    pending_o = expected_blocks.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHACAL-2 cipher unit testbench
// Drives key loads, encrypt and decrypt beats and ignored operations through
// the cipher unit under four handshake pressure phases, with one long output
// hold that backs the pipeline up. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import shacal2_pkg::*;

  localparam int unsigned Rounds = RoundsDefault;
  localparam int StallLimit = 4000;
  localparam int LongHold   = 300;
  localparam int PhaseItems = 275;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [OpW-1:0]       operation_i  = OP_IGNORE;
  logic [KeyIndexW-1:0] key_index_i  = '0;
  logic [WordW-1:0]     key_word_i   = '0;
  logic [WordW-1:0]     in_word_a_i  = '0;
  logic [WordW-1:0]     in_word_b_i  = '0;
  logic [WordW-1:0]     in_word_c_i  = '0;
  logic [WordW-1:0]     in_word_d_i  = '0;
  logic [WordW-1:0]     in_word_e_i  = '0;
  logic [WordW-1:0]     in_word_f_i  = '0;
  logic [WordW-1:0]     in_word_g_i  = '0;
  logic [WordW-1:0]     in_word_h_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [WordW-1:0]     out_word_a_o;
  logic [WordW-1:0]     out_word_b_o;
  logic [WordW-1:0]     out_word_c_o;
  logic [WordW-1:0]     out_word_d_o;
  logic [WordW-1:0]     out_word_e_o;
  logic [WordW-1:0]     out_word_f_o;
  logic [WordW-1:0]     out_word_g_o;
  logic [WordW-1:0]     out_word_h_o;

  int mismatches;
  int results_pending;
  int results_checked;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;
  int quiet_cycles   = 0;
  int encrypt_beats  = 0;
  int decrypt_beats  = 0;
  int load_beats     = 0;
  int ignored_beats  = 0;

  shacal2_block_cipher_unit #(.Rounds(Rounds)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .key_index_i, .key_word_i,
    .in_word_a_i, .in_word_b_i, .in_word_c_i, .in_word_d_i,
    .in_word_e_i, .in_word_f_i, .in_word_g_i, .in_word_h_i,
    .out_valid_o, .out_ready_i,
    .out_word_a_o, .out_word_b_o, .out_word_c_o, .out_word_d_o,
    .out_word_e_o, .out_word_f_o, .out_word_g_o, .out_word_h_o
  );

  shacal2_result_checker #(.Rounds(Rounds)) result_check (
    .clk_i, .rst_ni, .in_valid_i,
    .in_ready_i   (in_ready_o),
    .operation_i, .key_index_i, .key_word_i,
    .in_word_a_i, .in_word_b_i, .in_word_c_i, .in_word_d_i,
    .in_word_e_i, .in_word_f_i, .in_word_g_i, .in_word_h_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .out_word_a_i (out_word_a_o),
    .out_word_b_i (out_word_b_o),
    .out_word_c_i (out_word_c_o),
    .out_word_d_i (out_word_d_o),
    .out_word_e_i (out_word_e_o),
    .out_word_f_i (out_word_f_o),
    .out_word_g_i (out_word_g_o),
    .out_word_h_i (out_word_h_o),
    .mismatches_o (mismatches),
    .pending_o    (results_pending),
    .checked_o    (results_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // output side: random stalls, plus a long hold whenever one is requested
  initial begin : receiver
    int served;
    int hold_left;
    served    = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_reqs != served) begin
        served++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no beat accepted for %0d cycles", StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KeyIndexW-1:0] rand_index();
    return KeyIndexW'($urandom_range(63));
  endfunction

  function automatic block_t rand_block();
    block_t b;
    for (int i = 0; i < 8; i++) b[i] = rand_word();
    return b;
  endfunction

  task automatic send_beat(input op_e op, input logic [KeyIndexW-1:0] idx,
                           input word_t key, input block_t blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_index_i <= idx;
    key_word_i  <= key;
    in_word_a_i <= blk[0];
    in_word_b_i <= blk[1];
    in_word_c_i <= blk[2];
    in_word_d_i <= blk[3];
    in_word_e_i <= blk[4];
    in_word_f_i <= blk[5];
    in_word_g_i <= blk[6];
    in_word_h_i <= blk[7];
    do @(posedge clk_i); while (!in_ready_o);
    case (op)
      OP_LOAD:    load_beats++;
      OP_ENCRYPT: encrypt_beats++;
      OP_DECRYPT: decrypt_beats++;
      default:    ignored_beats++;
    endcase
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    while (results_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int   n;
    int   pick;
    op_e  op;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // store still all zero, key fields ignored on blocks
    send_beat(OP_ENCRYPT, rand_index(), rand_word(), {8{32'h0000_0000}});
    send_beat(OP_ENCRYPT, rand_index(), rand_word(), {8{32'hFFFF_FFFF}});
    send_beat(OP_DECRYPT, rand_index(), rand_word(), {8{32'h0000_0000}});
    send_beat(OP_DECRYPT, rand_index(), rand_word(), {8{32'hFFFF_FFFF}});
    // ignored op must leave the store alone
    send_beat(OP_IGNORE, 6'd0, 32'hFFFF_FFFF, rand_block());
    send_beat(OP_ENCRYPT, 6'd0, 32'h0, {8{32'h0000_0000}});
    // loads at the index and value extremes, block words ignored
    send_beat(OP_LOAD, 6'd0, 32'hFFFF_FFFF, rand_block());
    send_beat(OP_LOAD, 6'd63, 32'hFFFF_FFFF, rand_block());
    send_beat(OP_LOAD, 6'd31, 32'h8000_0001, rand_block());
    send_beat(OP_ENCRYPT, rand_index(), rand_word(), {8{32'h0000_0000}});
    send_beat(OP_DECRYPT, rand_index(), rand_word(), {8{32'h0000_0000}});
    send_beat(OP_ENCRYPT, rand_index(), rand_word(), {4{32'hAAAA_AAAA, 32'h5555_5555}});
    send_beat(OP_DECRYPT, rand_index(), rand_word(), {4{32'h5555_5555, 32'hAAAA_AAAA}});
    send_beat(OP_IGNORE, 6'd63, 32'h0, rand_block());
    send_beat(OP_ENCRYPT, rand_index(), rand_word(), rand_block());
    send_beat(OP_LOAD, 6'd63, 32'h0000_0000, rand_block());
    send_beat(OP_LOAD, 6'd0, 32'h0000_0000, rand_block());
    send_beat(OP_ENCRYPT, rand_index(), rand_word(), {8{32'hFFFF_FFFF}});
    send_beat(OP_DECRYPT, rand_index(), rand_word(), rand_block());
    in_valid_i <= 1'b0;
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 50; end
        default: begin send_idle_pct = 19; recv_stall_pct <= 19; end
      endcase
      n = 0;
      while (n < PhaseItems) begin
        pick = $urandom_range(99);
        if (phase == 0 && n == 100) hold_reqs <= hold_reqs + 1;
        // keep blocks flowing during the long hold so the pipeline fills
        if (phase == 0 && n >= 100 && n < 200) begin
          if (pick < 50) op = OP_ENCRYPT;
          else op = OP_DECRYPT;
        end else if (pick < 12) begin
          op = OP_LOAD;
        end else if (pick < 15) begin
          op = OP_IGNORE;
        end else if (pick < 58) begin
          op = OP_ENCRYPT;
        end else begin
          op = OP_DECRYPT;
        end
        send_beat(op, rand_index(), rand_word(), rand_block());
        if (op != OP_IGNORE) n++;
      end
      in_valid_i <= 1'b0;
      wait_for_results();
    end

    repeat (Rounds + 20) @(posedge clk_i);
    $display("Covered %0d encrypt, %0d decrypt, %0d key load and %0d ignored beats",
             encrypt_beats, decrypt_beats, load_beats, ignored_beats);
    $display("%0d result blocks compared over four pressure phases and one long output hold",
             results_checked);
    if (mismatches == 0 && results_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/shacal2_pkg.sv
hdl/shacal2_stage.sv
hdl/shacal2_block_cipher_unit.sv
test/shacal2_result_checker.sv
test/testbench.sv
